>>> rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants for the point perspective projector
// Register indexes, config bundle, front-to-back request record and the
// truncating fixed-point helpers.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 54;
  localparam int RatioBits   = 11;   // ratio <= 0x400
  localparam int ScrBits     = 18;   // |p| / (ratio*256) < 2**18

  localparam logic signed [32:0] AxisLimit = 33'sh3ffffff;
  localparam logic signed [33:0] NearDepth = 34'sh0020_0000;
  localparam logic [RatioBits-1:0] RatioMin = 11'h20;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_ROW_A   = 3'd0,
    REG_ROW_B   = 3'd1,
    REG_ROW_C   = 3'd2,
    REG_EYE_X   = 3'd3,
    REG_EYE_Y   = 3'd4,
    REG_EYE_Z   = 3'd5,
    REG_REF_H   = 3'd6,
    REG_OFFSETS = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [53:0]        row_a;
    logic [53:0]        row_b;
    logic [35:0]        row_c;
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] ref_height;
    logic [47:0]        offsets;
  } cfg_t;

  // one request handed from front to back
  typedef struct packed {
    logic               cull;
    logic [32:0]        num;   // dividend for the depth ratio
    logic [30:0]        den;   // divisor for the depth ratio
    logic signed [31:0] px;
    logic signed [31:0] py;
  } item_t;

  // offset / 128, toward zero (valid for in-range offsets)
  function automatic logic signed [19:0] div128(input logic signed [32:0] v);
    logic signed [32:0] t;
    t = v + (v[32] ? 33'sd127 : 33'sd0);
    return t[26:7];
  endfunction

  // basis / 16, toward zero
  function automatic logic signed [13:0] div16(input logic signed [17:0] b);
    logic signed [17:0] t;
    t = b + (b[17] ? 18'sd15 : 18'sd0);
    return t[17:4];
  endfunction

  // product / 32, toward zero
  function automatic logic signed [28:0] div32(input logic signed [33:0] p);
    logic signed [33:0] t;
    t = p + (p[33] ? 34'sd31 : 34'sd0);
    return t[33:5];
  endfunction

endpackage

>>> rtl/ppp_front.sv
// ----------------------------------------------------------------------------
// ppp_front: range check, rotation and depth classification
// Five-stage pipeline that turns an object position into a division request.
// ----------------------------------------------------------------------------
module ppp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] obj_x,
  input  logic signed [31:0] obj_y,
  input  ppp_pkg::cfg_t      cfg,
  output logic               out_valid,
  output ppp_pkg::item_t     item
);
  import ppp_pkg::*;

  // stage 1
  logic signed [32:0] dx, dy, dz;
  logic               s1_valid, s1_cull;
  logic signed [19:0] s1_ox, s1_oy, s1_oz;
  // stage 2
  logic               s2_valid, s2_cull;
  logic signed [28:0] t_ax, t_ay, t_az, t_bx, t_by, t_bz, t_cy, t_cz;
  // stage 3
  logic               s3_valid, s3_cull;
  logic signed [31:0] s3_px, s3_py, pz;
  logic signed [33:0] s3_depth;
  // stage 4
  logic               s4_valid, s4_cull, near;
  logic signed [31:0] s4_px, s4_py;
  logic [32:0]        s4_num;
  logic [30:0]        s4_den;
  logic [41:0]        lim;

  assign dx = {obj_x[31], obj_x} - {cfg.eye_x[31], cfg.eye_x};
  assign dy = {obj_y[31], obj_y} - {cfg.eye_y[31], cfg.eye_y};
  assign dz = 33'sd0 - {cfg.eye_z[31], cfg.eye_z};

  always_ff @(posedge clk) begin
    s1_cull <= (dx < -AxisLimit) || (dx > AxisLimit) || (dy < -AxisLimit) ||
               (dy > AxisLimit) || (dz < -AxisLimit) || (dz > AxisLimit);
    s1_ox   <= div128(dx);
    s1_oy   <= div128(dy);
    s1_oz   <= div128(dz);
  end

  // rotation products, row C has no x term
  always_ff @(posedge clk) begin
    s2_cull <= s1_cull;
    t_ax <= div32(34'(div16(cfg.row_a[17:0]))  * 34'(s1_ox));
    t_ay <= div32(34'(div16(cfg.row_a[35:18])) * 34'(s1_ox));
    t_az <= div32(34'(div16(cfg.row_a[53:36])) * 34'(s1_ox));
    t_bx <= div32(34'(div16(cfg.row_b[17:0]))  * 34'(s1_oy));
    t_by <= div32(34'(div16(cfg.row_b[35:18])) * 34'(s1_oy));
    t_bz <= div32(34'(div16(cfg.row_b[53:36])) * 34'(s1_oy));
    t_cy <= div32(34'(div16(cfg.row_c[17:0]))  * 34'(s1_oz));
    t_cz <= div32(34'(div16(cfg.row_c[35:18])) * 34'(s1_oz));
  end

  assign pz = 32'(t_az) + 32'(t_bz) + 32'(t_cz);

  always_ff @(posedge clk) begin
    s3_cull  <= s2_cull;
    s3_px    <= 32'(t_ax) + 32'(t_bx);
    s3_py    <= 32'(t_ay) + 32'(t_by) + 32'(t_cy);
    s3_depth <= 34'(cfg.ref_height) - 34'(pz);
  end

  // near depth: (depth*256)/h, far depth: depth/(h/256)
  assign near = s3_depth < NearDepth;

  always_ff @(posedge clk) begin
    s4_px <= s3_px;
    s4_py <= s3_py;
    if (near) begin
      s4_cull <= s3_cull || (s3_depth <= 34'sd0) || (cfg.ref_height <= 32'sd0);
      s4_num  <= {s3_depth[24:0], 8'd0};
      s4_den  <= cfg.ref_height[30:0];
    end else begin
      s4_cull <= s3_cull || (cfg.ref_height < 32'sd256);
      s4_num  <= s3_depth[32:0];
      s4_den  <= {8'd0, cfg.ref_height[30:8]};
    end
  end

  // ratio > 0x400 exactly when num >= den * 0x401
  assign lim = ({11'd0, s4_den} << 10) + {11'd0, s4_den};

  always_ff @(posedge clk) begin
    item.cull <= s4_cull || ({9'd0, s4_num} >= lim);
    item.num  <= s4_num;
    item.den  <= s4_den;
    item.px   <= s4_px;
    item.py   <= s4_py;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

endmodule

>>> rtl/ppp_fifo.sv
// ----------------------------------------------------------------------------
// ppp_fifo: two-entry request queue between front and back
// Drained whenever it holds a request.
// ----------------------------------------------------------------------------
module ppp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ppp_pkg::item_t push_item,
  output logic           out_valid,
  output ppp_pkg::item_t out_item
);
  import ppp_pkg::*;

  item_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic       pop;

  assign pop       = count != 2'd0;
  assign out_valid = pop;
  assign out_item  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    else if (!push && pop) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

endmodule

>>> rtl/ppp_back.sv
// ----------------------------------------------------------------------------
// ppp_back: depth ratio and screen position dividers
// Pipelined restoring dividers, one quotient bit per stage, then offsets.
// ----------------------------------------------------------------------------
module ppp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ppp_pkg::item_t     item,
  input  ppp_pkg::cfg_t      cfg,
  output logic               done,
  output logic               visible,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic [12:0]        draw_scale
);
  import ppp_pkg::*;

  // ratio divider
  logic                 r_vld  [RatioBits+1];
  logic                 r_cull [RatioBits+1];
  logic [32:0]          r_rem  [RatioBits+1];
  logic [30:0]          r_den  [RatioBits+1];
  logic [RatioBits-1:0] r_q    [RatioBits+1];
  logic signed [31:0]   r_px   [RatioBits+1];
  logic signed [31:0]   r_py   [RatioBits+1];
  // screen divider
  logic                 s_vld  [ScrBits+1];
  logic                 s_cull [ScrBits+1];
  logic [RatioBits-1:0] s_rat  [ScrBits+1];
  logic [30:0]          s_rx   [ScrBits+1];
  logic [30:0]          s_ry   [ScrBits+1];
  logic                 s_nx   [ScrBits+1];
  logic                 s_ny   [ScrBits+1];
  logic [ScrBits-1:0]   s_qx   [ScrBits+1];
  logic [ScrBits-1:0]   s_qy   [ScrBits+1];

  logic [RatioBits-1:0] ratio;
  logic [31:0]          mag_x, mag_y;
  logic [15:0]          sx, sy;

  assign ratio = r_q[RatioBits];
  assign mag_x = r_px[RatioBits][31] ? 32'(-r_px[RatioBits]) : 32'(r_px[RatioBits]);
  assign mag_y = r_py[RatioBits][31] ? 32'(-r_py[RatioBits]) : 32'(r_py[RatioBits]);

  always_ff @(posedge clk) begin
    r_cull[0] <= item.cull;
    r_rem[0]  <= item.num;
    r_den[0]  <= item.den;
    r_q[0]    <= '0;
    r_px[0]   <= item.px;
    r_py[0]   <= item.py;
    for (int k = 0; k < RatioBits; k++) begin
      logic [41:0] dsh;
      logic [41:0] rem;
      dsh = {11'd0, r_den[k]} << (RatioBits - 1 - k);
      rem = {9'd0, r_rem[k]};
      r_cull[k+1] <= r_cull[k];
      r_den[k+1]  <= r_den[k];
      r_px[k+1]   <= r_px[k];
      r_py[k+1]   <= r_py[k];
      if (rem >= dsh) begin
        r_rem[k+1] <= 33'(rem - dsh);
        r_q[k+1]   <= r_q[k] | (RatioBits'(1) << (RatioBits - 1 - k));
      end else begin
        r_rem[k+1] <= r_rem[k];
        r_q[k+1]   <= r_q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    s_cull[0] <= r_cull[RatioBits] || (ratio < RatioMin);
    s_rat[0]  <= ratio;
    s_rx[0]   <= mag_x[30:0];
    s_ry[0]   <= mag_y[30:0];
    s_nx[0]   <= r_px[RatioBits][31];
    s_ny[0]   <= r_py[RatioBits][31];
    s_qx[0]   <= '0;
    s_qy[0]   <= '0;
    for (int k = 0; k < ScrBits; k++) begin
      logic [36:0] dsh;
      dsh = {18'd0, s_rat[k], 8'd0} << (ScrBits - 1 - k);
      s_cull[k+1] <= s_cull[k];
      s_rat[k+1]  <= s_rat[k];
      s_nx[k+1]   <= s_nx[k];
      s_ny[k+1]   <= s_ny[k];
      if ({6'd0, s_rx[k]} >= dsh) begin
        s_rx[k+1] <= 31'({6'd0, s_rx[k]} - dsh);
        s_qx[k+1] <= s_qx[k] | (ScrBits'(1) << (ScrBits - 1 - k));
      end else begin
        s_rx[k+1] <= s_rx[k];
        s_qx[k+1] <= s_qx[k];
      end
      if ({6'd0, s_ry[k]} >= dsh) begin
        s_ry[k+1] <= 31'({6'd0, s_ry[k]} - dsh);
        s_qy[k+1] <= s_qy[k] | (ScrBits'(1) << (ScrBits - 1 - k));
      end else begin
        s_ry[k+1] <= s_ry[k];
        s_qy[k+1] <= s_qy[k];
      end
    end
  end

  // sign back on, then add screen offsets, wrap to 16 bits
  assign sx = (s_nx[ScrBits] ? 16'(-s_qx[ScrBits]) : s_qx[ScrBits][15:0])
              + cfg.offsets[15:0];
  assign sy = (s_ny[ScrBits] ? 16'(-s_qy[ScrBits]) : s_qy[ScrBits][15:0])
              + cfg.offsets[31:16] + cfg.offsets[47:32];

  always_ff @(posedge clk) begin
    if (s_cull[ScrBits]) begin
      visible    <= 1'b0;
      screen_x   <= '0;
      screen_y   <= '0;
      draw_scale <= '0;
    end else begin
      visible    <= 1'b1;
      screen_x   <= sx;
      screen_y   <= sy;
      draw_scale <= {s_rat[ScrBits], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= RatioBits; k++) r_vld[k] <= 1'b0;
      for (int k = 0; k <= ScrBits; k++) s_vld[k] <= 1'b0;
      done <= 1'b0;
    end else begin
      r_vld[0] <= in_valid;
      for (int k = 0; k < RatioBits; k++) r_vld[k+1] <= r_vld[k];
      s_vld[0] <= r_vld[RatioBits];
      for (int k = 0; k < ScrBits; k++) s_vld[k+1] <= s_vld[k];
      done <= s_vld[ScrBits];
    end
  end

endmodule

>>> rtl/point_perspective_projector_top.sv
// ----------------------------------------------------------------------------
// point_perspective_projector_top: ground point to screen projection
// Config registers, front pipeline, request queue and divider back end.
// ----------------------------------------------------------------------------
// Usage:
//   Config: write register cfg_index with cfg_data while cfg_we is high;
//   taken at that clock edge. Write only while no request is in flight.
//   Request: drive obj_x/obj_y with start high; accepted at an edge where
//   busy is low. busy falls in the cycle after reset leaves, so a request
//   can be issued every cycle (one per clock sustained).
//   Result: done is high for one cycle with visible, screen_x, screen_y and
//   draw_scale. Culled points show visible=0 and all-zero fields.
//   Between the accepting edge and done lie 38 register stages: the 5-stage
//   front, the queue slot, the ratio divider (input stage plus 11 quotient
//   stages), the screen divider (input stage plus 18 quotient stages) and
//   the output register.
//   Results come out in request order; the receiver cannot stall, so the
//   queue never backs up.
//   Reset (rst, synchronous) clears all config registers to zero and drops
//   every request in flight.
// ----------------------------------------------------------------------------
module point_perspective_projector_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              obj_x,
  input  logic signed [31:0]              obj_y,
  input  logic                            cfg_we,
  input  logic [ppp_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [ppp_pkg::CfgDataBits-1:0] cfg_data,
  output logic                            done,
  output logic                            visible,
  output logic signed [15:0]              screen_x,
  output logic signed [15:0]              screen_y,
  output logic [12:0]                     draw_scale
);
  import ppp_pkg::*;

  cfg_t  cfg;
  logic  accept;
  logic  f_valid, q_valid;
  item_t f_item, q_item;

  // busy only covers the reset window
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  // config register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_A:   cfg.row_a      <= cfg_data;
        REG_ROW_B:   cfg.row_b      <= cfg_data;
        REG_ROW_C:   cfg.row_c      <= cfg_data[35:0];
        REG_EYE_X:   cfg.eye_x      <= cfg_data[31:0];
        REG_EYE_Y:   cfg.eye_y      <= cfg_data[31:0];
        REG_EYE_Z:   cfg.eye_z      <= cfg_data[31:0];
        REG_REF_H:   cfg.ref_height <= cfg_data[31:0];
        REG_OFFSETS: cfg.offsets    <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // front: range check, rotate, classify depth
  ppp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .obj_x    (obj_x),
    .obj_y    (obj_y),
    .cfg      (cfg),
    .out_valid(f_valid),
    .item     (f_item)
  );

  // short queue decoupling front from back
  ppp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (f_valid),
    .push_item(f_item),
    .out_valid(q_valid),
    .out_item (q_item)
  );

  // back: ratio and screen dividers, output register
  ppp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .item      (q_item),
    .cfg       (cfg),
    .done      (done),
    .visible   (visible),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .draw_scale(draw_scale)
  );

endmodule

>>> rtl/ppp_checker.sv
// ----------------------------------------------------------------------------
// ppp_checker: port-level checks on the projector
// Result strobe and payload consistency over time.
// ----------------------------------------------------------------------------
module ppp_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input logic               visible,
  input logic signed [15:0] screen_x,
  input logic signed [15:0] screen_y,
  input logic [12:0]        draw_scale
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done && busy)
    else $error("result or ready during reset");

  a_cull_zero: assert property (@(posedge clk) disable iff (rst)
    done && !visible |-> screen_x == 16'sd0 && screen_y == 16'sd0 && draw_scale == 13'd0)
    else $error("culled result with nonzero fields");

  a_scale_range: assert property (@(posedge clk) disable iff (rst)
    done && visible |-> draw_scale >= 13'd128 && draw_scale <= 13'd4096)
    else $error("scale out of range");

  a_scale_step: assert property (@(posedge clk) disable iff (rst)
    done && visible |-> draw_scale[1:0] == 2'b00)
    else $error("scale not a multiple of four");

endmodule

bind point_perspective_projector_top ppp_checker u_ppp_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .done      (done),
  .visible   (visible),
  .screen_x  (screen_x),
  .screen_y  (screen_y),
  .draw_scale(draw_scale)
);

>>> bench/projection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projection_checker: screen projection predictor and result compare
// Mirrors the config writes, works out the screen position for every
// accepted request and checks each done strobe against the oldest one.
// ----------------------------------------------------------------------------
module projection_checker
  import ppp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic signed [31:0]     obj_x,
  input  logic signed [31:0]     obj_y,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data,
  input  logic                   done,
  input  logic                   visible,
  input  logic signed [15:0]     screen_x,
  input  logic signed [15:0]     screen_y,
  input  logic [12:0]            draw_scale,
  output int                     errors,
  output int                     pending
);

  typedef struct {
    logic        vis;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [12:0] scale;
  } screen_pt_t;

  cfg_t       cam;
  screen_pt_t expected_pts[$];

  function automatic longint rot_term(longint b, longint off);
    return ((b / 16) * (off / 128)) / 32;
  endfunction

  function automatic longint s18(logic [17:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint s16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic screen_pt_t project_point(logic signed [31:0] ox,
                                               logic signed [31:0] oy);
    screen_pt_t r;
    longint dx, dy, dz, h, px, py, pz, depth, ratio, sx, sy, d;
    r = '{1'b0, 16'd0, 16'd0, 13'd0};
    dx = longint'(ox) - longint'(cam.eye_x);
    dy = longint'(oy) - longint'(cam.eye_y);
    dz = -longint'(cam.eye_z);
    h  = longint'(cam.ref_height);
    if (dx > 64'sh3ffffff || dx < -64'sh3ffffff || dy > 64'sh3ffffff ||
        dy < -64'sh3ffffff || dz > 64'sh3ffffff || dz < -64'sh3ffffff)
      return r;
    px = rot_term(s18(cam.row_a[17:0]), dx) + rot_term(s18(cam.row_b[17:0]), dy);
    py = rot_term(s18(cam.row_a[35:18]), dx) + rot_term(s18(cam.row_b[35:18]), dy)
       + rot_term(s18(cam.row_c[17:0]), dz);
    pz = rot_term(s18(cam.row_a[53:36]), dx) + rot_term(s18(cam.row_b[53:36]), dy)
       + rot_term(s18(cam.row_c[35:18]), dz);
    depth = h - pz;
    if (depth <= 0) return r;
    // near objects scale against the full height, far ones against height/256
    if (depth < 64'sh200000) begin
      if (h == 0) return r;
      ratio = (depth * 256) / h;
    end else begin
      d = h / 256;
      if (d == 0) return r;
      ratio = depth / d;
    end
    if (ratio < 32 || ratio > 1024) return r;
    sx = (px / ratio) / 256 + s16(cam.offsets[15:0]);
    sy = (py / ratio) / 256 + s16(cam.offsets[31:16]) + s16(cam.offsets[47:32]);
    r.vis   = 1'b1;
    r.sx    = sx[15:0];
    r.sy    = sy[15:0];
    r.scale = 13'(ratio * 4);
    return r;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    screen_pt_t e;
    if (rst) begin
      cam = '0;
      expected_pts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROW_A:   cam.row_a      = cfg_data[53:0];
          REG_ROW_B:   cam.row_b      = cfg_data[53:0];
          REG_ROW_C:   cam.row_c      = cfg_data[35:0];
          REG_EYE_X:   cam.eye_x      = cfg_data[31:0];
          REG_EYE_Y:   cam.eye_y      = cfg_data[31:0];
          REG_EYE_Z:   cam.eye_z      = cfg_data[31:0];
          REG_REF_H:   cam.ref_height = cfg_data[31:0];
          REG_OFFSETS: cam.offsets    = cfg_data[47:0];
          default: ;
        endcase
      end
      if (done) begin
        if (expected_pts.size() == 0) begin
          $error("unexpected result: no request outstanding");
          errors++;
        end else begin
          e = expected_pts.pop_front();
          if (visible !== e.vis) begin
            $error("visible: expected %0d, got %0d", e.vis, visible);
            errors++;
          end
          if (screen_x !== e.sx) begin
            $error("screen_x: expected %0h, got %0h", e.sx, screen_x);
            errors++;
          end
          if (screen_y !== e.sy) begin
            $error("screen_y: expected %0h, got %0h", e.sy, screen_y);
            errors++;
          end
          if (draw_scale !== e.scale) begin
            $error("draw_scale: expected %0h, got %0h", e.scale, draw_scale);
            errors++;
          end
        end
      end
      if (start && !busy) expected_pts.push_back(project_point(obj_x, obj_y));
    end
    pending = expected_pts.size();
  end

endmodule

>>> bench/tb_point_perspective_projector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_perspective_projector_top: projector regression bench
// Loads a series of camera setups (plain, extreme, random), pushes directed
// and random ground points through, and lets the checker compare every
// projected point. Sender gaps vary by phase.
// ----------------------------------------------------------------------------
module tb_point_perspective_projector_top;
  import ppp_pkg::*;

  localparam int LATENCY = 38;
  localparam int NUM_SETUPS = 10;
  localparam int PTS_PER_SETUP = 50;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic signed [31:0]     obj_x = '0;
  logic signed [31:0]     obj_y = '0;
  logic                   cfg_we = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  logic                   done;
  logic                   visible;
  logic signed [15:0]     screen_x;
  logic signed [15:0]     screen_y;
  logic [12:0]            draw_scale;
  int                     errors;
  int                     pending;

  // camera setup staged here, then written out in register order
  logic [53:0] cam_regs [8];
  int          idle_pct;

  always #5 clk = ~clk;

  point_perspective_projector_top dut (.*);

  projection_checker chk (.*);

  function automatic logic [53:0] pack3(int x, int y, int z);
    logic [17:0] a, b, c;
    a = x[17:0];
    b = y[17:0];
    c = z[17:0];
    return {c, b, a};
  endfunction

  function automatic int srand(int span);
    return int'($urandom_range(2 * span, 0)) - span;
  endfunction

  task automatic load_camera();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= cam_regs[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // pipeline must be empty before a config write
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
    int gap;
    gap = 0;
    while (int'($urandom_range(99, 0)) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    obj_x <= x;
    obj_y <= y;
    do @(posedge clk); while (busy);
  endtask

  // well-behaved camera: small depth terms so most points land on screen
  task automatic plain_camera();
    cam_regs[REG_ROW_A]   = pack3(32768, 0, 0);
    cam_regs[REG_ROW_B]   = pack3(0, 32768, 0);
    cam_regs[REG_ROW_C]   = '0;
    cam_regs[REG_EYE_X]   = '0;
    cam_regs[REG_EYE_Y]   = '0;
    cam_regs[REG_EYE_Z]   = '0;
    cam_regs[REG_REF_H]   = 54'h100000;
    cam_regs[REG_OFFSETS] = '0;
  endtask

  task automatic random_camera(bit wild);
    logic [31:0] h;
    cam_regs[REG_ROW_A] = pack3(srand(131071), srand(131071), srand(1 << $urandom_range(16, 4)));
    cam_regs[REG_ROW_B] = pack3(srand(131071), srand(131071), srand(1 << $urandom_range(16, 4)));
    cam_regs[REG_ROW_C] = 54'({18'(srand(1 << $urandom_range(16, 4))), 18'(srand(131071))});
    cam_regs[REG_EYE_X] = 54'($urandom());
    cam_regs[REG_EYE_Y] = 54'($urandom());
    cam_regs[REG_EYE_Z] = 54'(32'(srand(1 << $urandom_range(26, 8))));
    case ($urandom_range(5, 0))
      0:       h = 32'($urandom_range(255, 0));             // far divisor goes to zero
      1:       h = -32'($urandom_range(32'h100000, 1));     // negative height
      default: h = 32'($urandom_range(32'h4000000, 32'h1000));
    endcase
    cam_regs[REG_REF_H]   = 54'(h);
    cam_regs[REG_OFFSETS] = {6'd0, $urandom(), 16'($urandom())};
    if (wild)
      for (int i = 0; i < 8; i++) cam_regs[i] = {22'($urandom()), $urandom()};
  endtask

  task automatic random_point();
    logic signed [31:0] ex, ey;
    ex = cam_regs[REG_EYE_X][31:0];
    ey = cam_regs[REG_EYE_Y][31:0];
    case ($urandom_range(9, 0))
      0: send_point($urandom(), $urandom());
      1: send_point(ex + 32'sh3ffffff + $urandom_range(1, 0),
                    ey - 32'sh3ffffff - $urandom_range(1, 0));
      default: send_point(ex + srand(1 << $urandom_range(26, 10)),
                          ey + srand(1 << $urandom_range(26, 10)));
    endcase
  endtask

  initial begin
    #20_000_000;
    $display("point_perspective_projector_top regression: fail");
    $finish;
  end

  initial begin
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: axis limits, extremes of the object position
    plain_camera();
    load_camera();
    send_point(0, 0);
    send_point(32'sh3ffffff, 0);
    send_point(32'sh4000000, 0);
    send_point(-32'sh3ffffff, 32'sh3ffffff);
    send_point(0, -32'sh4000000);
    send_point(32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh80000000);
    send_point(32'sh00200000, -32'sh00300000);
    send_point(-32'sh01000000, 32'sh02000000);
    // hold off until the pipeline is empty
    drain();

    // depth-axis limit, zero and negative heights, all-ones and all-min regs
    cam_regs[REG_EYE_Z] = 54'(32'sh3ffffff);
    cam_regs[REG_ROW_C] = 54'({18'sd100, 18'sd0});
    load_camera();
    send_point(32'sh100000, 32'sh100000);
    drain();
    cam_regs[REG_EYE_Z] = 54'(-32'sh4000000);
    load_camera();
    send_point(32'sh100000, 32'sh100000);
    drain();
    plain_camera();
    cam_regs[REG_REF_H] = '0;
    load_camera();
    send_point(32'sh100000, 0);
    drain();
    cam_regs[REG_REF_H] = 54'(32'hffff0000);
    load_camera();
    send_point(32'sh100000, 0);
    drain();
    for (int i = 0; i < 8; i++) cam_regs[i] = '1;
    load_camera();
    send_point(0, 0);
    send_point(-1, -1);
    drain();
    for (int i = 0; i < 8; i++) cam_regs[i] = '0;
    cam_regs[REG_ROW_A]   = {18'h20000, 18'h20000, 18'h20000};
    cam_regs[REG_ROW_B]   = {18'h20000, 18'h20000, 18'h20000};
    cam_regs[REG_ROW_C]   = 54'({18'h20000, 18'h20000});
    cam_regs[REG_EYE_X]   = 54'h80000000;
    cam_regs[REG_EYE_Y]   = 54'h80000000;
    cam_regs[REG_REF_H]   = 54'h7fffffff;
    cam_regs[REG_OFFSETS] = 54'h800080008000;
    load_camera();
    send_point(32'sh80000000, 32'sh80000000);
    send_point(32'sh83ffffff, 32'sh7c000001);
    drain();

    // random setups; idle phases rotate across them
    for (int s = 0; s < NUM_SETUPS; s++) begin
      random_camera(s == NUM_SETUPS - 1);
      load_camera();
      case (s % 4)
        0: idle_pct = 0;
        1: idle_pct = 77;
        2: idle_pct = 0;
        default: idle_pct = 21;
      endcase
      for (int n = 0; n < PTS_PER_SETUP; n++) random_point();
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("point_perspective_projector_top regression: pass");
    end else begin
      $display("point_perspective_projector_top regression: fail");
    end
    $finish;
  end

endmodule
